/* hdl/two_axis_velocity_kalman_core_defines.svh */
// Assertion macros shared by the verification files of the velocity Kalman core.
// Each macro expects signals named i_clk and i_rst_n in the scope where it is used.
`ifndef TWO_AXIS_VELOCITY_KALMAN_CORE_DEFINES_SVH
`define TWO_AXIS_VELOCITY_KALMAN_CORE_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent, outside reset.
`define KVK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kvk assertion failed");

// The condition must hold at every clock edge outside reset.
`define KVK_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("kvk assertion failed");

// A property checked at every edge, reset included.
`define KVK_ASSERT_RAW(label, prop) \
    label: assert property (@(posedge i_clk) (prop)) \
        else $error("kvk assertion failed");

`endif

/* hdl/kvk_pkg.sv */
// Package of the two-axis velocity Kalman core: types, register map and helpers.
// No dependencies; the divider, the lanes and the top level import it.
`default_nettype none

package kvk_pkg;

    // Fixed field widths.
    localparam int DT_BITS   = 16;
    localparam int CFG_W     = 24;
    localparam int ADDR_W    = 4;

    // Register map indexes (address bits [3:2]).
    localparam logic [1:0] REG_Q_VEL   = 2'd0;
    localparam logic [1:0] REG_Q_DRIFT = 2'd1;
    localparam logic [1:0] REG_R_MEAS  = 2'd2;

    // Reset values of the noise registers.
    localparam logic [CFG_W-1:0] RST_Q_VEL   = 24'd3277;
    localparam logic [CFG_W-1:0] RST_Q_DRIFT = 24'd32768;
    localparam logic [CFG_W-1:0] RST_R_MEAS  = 24'd327680;

    // Sequencer states of one axis lane.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRED_V,
        ST_T00,
        ST_T01,
        ST_PP00,
        ST_DIV,
        ST_VEL,
        ST_DRIFT,
        ST_P00,
        ST_P01,
        ST_P10,
        ST_P11,
        ST_DONE
    } t_lane_st;

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] res;
        if (v > 66'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end else if (v < -66'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* hdl/kvk_if.sv */
// Valid/ready channel interfaces for the input tick and the estimate result.
// No dependencies.
`default_nettype none

interface kvk_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic [15:0]        time_step;
    logic               source_ready;
    logic               new_measure;
    logic signed [31:0] meas_vel_x;
    logic signed [31:0] meas_vel_y;

    modport source (output valid, accel_x, accel_y, time_step, source_ready, new_measure,
                    meas_vel_x, meas_vel_y, input ready);
    modport sink (input valid, accel_x, accel_y, time_step, source_ready, new_measure,
                  meas_vel_x, meas_vel_y, output ready);
endinterface

interface kvk_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] est_vel_x;
    logic signed [31:0] est_vel_y;
    logic               est_active;

    modport source (output valid, est_vel_x, est_vel_y, est_active, input ready);
    modport sink (input valid, est_vel_x, est_vel_y, est_active, output ready);
endinterface

`default_nettype wire

/* hdl/kvk_div.sv */
// Radix-4 restoring divider for the Kalman gain: (num * 2^FRAC_BITS) / den.
// Depends on kvk_pkg (sat32). Quotient truncates toward zero and saturates.
`default_nettype none

module kvk_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_num,
    input  wire logic [31:0]        i_den,
    output logic                    o_busy,
    output logic signed [31:0]      o_quot
);
    import kvk_pkg::*;

    localparam int NW = 32 + FRAC_BITS;
    localparam int NS = (NW + 1) / 2;
    localparam int NP = 2 * NS;
    localparam int CW = $clog2(NS + 1);

    logic [NP-1:0] r_dvd, n_dvd;
    logic [NP-1:0] r_quo, n_quo;
    logic [31:0]   r_rem, n_rem;
    logic [31:0]   r_den;
    logic [CW-1:0] r_cnt;
    logic          r_neg;
    logic          r_busy;
    logic [31:0]   w_mag;
    logic signed [65:0] w_q;
    logic signed [65:0] w_s;

    assign w_mag = i_num[31] ? 32'(-i_num) : 32'(i_num);

    // Two quotient bits per cycle.
    always_comb begin
        logic [32:0] rem33;
        logic        qbit;
        n_rem = r_rem;
        n_dvd = r_dvd;
        n_quo = r_quo;
        for (int i = 0; i < 2; i++) begin
            rem33 = {n_rem, n_dvd[NP-1]};
            n_dvd = n_dvd << 1;
            qbit  = 1'b0;
            if (rem33 >= {1'b0, r_den}) begin
                rem33 = rem33 - {1'b0, r_den};
                qbit  = 1'b1;
            end
            n_rem = rem33[31:0];
            n_quo = {n_quo[NP-2:0], qbit};
        end
    end

    // Control: iteration counter and busy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= NP'({w_mag, {FRAC_BITS{1'b0}}});
            r_rem <= '0;
            r_quo <= '0;
            r_den <= i_den;
            r_neg <= i_num[31];
        end else if (r_busy) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign w_q    = $signed(66'(r_quo));
    assign w_s    = r_neg ? -w_q : w_q;
    assign o_quot = sat32(w_s);
    assign o_busy = r_busy;

endmodule

`default_nettype wire

/* hdl/kvk_lane.sv */
// One axis of the velocity Kalman filter: state, covariance and a sequencer
// around one shared multiplier and two gain dividers. Depends on kvk_pkg, kvk_div.
`default_nettype none

module kvk_lane #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic                       i_fresh,
    input  wire logic                       i_zero,
    input  wire logic signed [31:0]         i_acc,
    input  wire logic [kvk_pkg::DT_BITS-1:0] i_dt,
    input  wire logic signed [31:0]         i_z,
    input  wire logic [kvk_pkg::CFG_W-1:0]  i_qv,
    input  wire logic [kvk_pkg::CFG_W-1:0]  i_qd,
    input  wire logic [kvk_pkg::CFG_W-1:0]  i_r,
    input  wire logic                       i_ack,
    output logic                            o_done,
    output logic signed [31:0]              o_vel
);
    import kvk_pkg::*;

    localparam logic signed [31:0] COV0   = 32'sd4 <<< FRAC_BITS;
    localparam logic signed [65:0] RND_DT = 66'sd1 <<< (DT_BITS - 1);
    localparam logic signed [65:0] RND_Q  = 66'sd1 <<< (FRAC_BITS - 1);

    t_lane_st r_st, n_st;
    logic     r_ph, n_ph;

    logic signed [31:0] r_vel, r_drift, r_p0, r_p1, r_p2, r_p3;
    logic signed [31:0] r_vp, r_t00, r_pp00, r_pp01, r_pp10, r_pp11;
    logic signed [31:0] r_k0, r_k1, r_innov;
    logic signed [31:0] r_acc, r_z;
    logic [DT_BITS-1:0] r_dt;
    logic               r_fresh, r_zero, r_kz;
    logic signed [65:0] r_prod;

    logic signed [32:0] w_a, w_b;
    logic               w_isq, w_sub;
    logic signed [31:0] w_base;
    logic [CFG_W-1:0]   w_c;
    logic signed [65:0] w_rdt, w_rq, w_mx, w_sum, w_sum2;
    logic signed [31:0] w_m, w_res, w_res2;
    logic signed [33:0] w_den;
    logic               w_div_go, w_busy0, w_busy1;
    logic signed [31:0] w_q0, w_q1;

    // Operand selection for the shared multiplier and the accumulate step.
    always_comb begin
        w_a    = '0;
        w_b    = '0;
        w_isq  = 1'b0;
        w_sub  = 1'b0;
        w_base = '0;
        w_c    = '0;
        case (r_st)
            ST_PRED_V: begin
                w_a    = 33'(r_drift) + 33'(r_acc);
                w_b    = $signed({17'd0, r_dt});
                w_base = r_zero ? 32'sd0 : r_vel;
            end
            ST_T00: begin
                w_a    = 33'(r_p2);
                w_b    = $signed({17'd0, r_dt});
                w_base = r_p0;
            end
            ST_T01: begin
                w_a    = 33'(r_p3);
                w_b    = $signed({17'd0, r_dt});
                w_base = r_p1;
            end
            ST_PP00: begin
                w_a    = 33'(r_pp01);
                w_b    = $signed({17'd0, r_dt});
                w_base = r_t00;
                w_c    = i_qv;
            end
            ST_VEL: begin
                w_a    = 33'(r_k0);
                w_b    = 33'(r_innov);
                w_isq  = 1'b1;
                w_base = r_vp;
            end
            ST_DRIFT: begin
                w_a    = 33'(r_k1);
                w_b    = 33'(r_innov);
                w_isq  = 1'b1;
                w_base = r_drift;
            end
            ST_P00: begin
                w_a    = 33'(r_k0);
                w_b    = 33'(r_pp00);
                w_isq  = 1'b1;
                w_sub  = 1'b1;
                w_base = r_pp00;
            end
            ST_P01: begin
                w_a    = 33'(r_k0);
                w_b    = 33'(r_pp01);
                w_isq  = 1'b1;
                w_sub  = 1'b1;
                w_base = r_pp01;
            end
            ST_P10: begin
                w_a    = 33'(r_k1);
                w_b    = 33'(r_pp00);
                w_isq  = 1'b1;
                w_sub  = 1'b1;
                w_base = r_pp10;
            end
            ST_P11: begin
                w_a    = 33'(r_k1);
                w_b    = 33'(r_pp01);
                w_isq  = 1'b1;
                w_sub  = 1'b1;
                w_base = r_pp11;
            end
            default: begin
                w_a = '0;
            end
        endcase
    end

    // Rounding shift of the registered product, then saturating accumulate.
    assign w_rdt  = (r_prod + RND_DT) >>> DT_BITS;
    assign w_rq   = (r_prod + RND_Q) >>> FRAC_BITS;
    assign w_m    = sat32(w_isq ? w_rq : w_rdt);
    assign w_mx   = 66'(w_m);
    assign w_sum  = 66'(w_base) + (w_sub ? -w_mx : w_mx) + $signed(66'(w_c));
    assign w_res  = sat32(w_sum);
    assign w_sum2 = 66'(r_p2) + w_mx;
    assign w_res2 = sat32(w_sum2);

    // Gain denominator, p00 + r.
    assign w_den    = 34'(r_pp00) + $signed(34'(i_r));
    assign w_div_go = (r_st == ST_DIV) && !r_ph;

    kvk_div #(.FRAC_BITS(FRAC_BITS)) u_div0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_go),
        .i_num   (r_pp00),
        .i_den   (w_den[31:0]),
        .o_busy  (w_busy0),
        .o_quot  (w_q0)
    );

    kvk_div #(.FRAC_BITS(FRAC_BITS)) u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_go),
        .i_num   (r_pp10),
        .i_den   (w_den[31:0]),
        .o_busy  (w_busy1),
        .o_quot  (w_q1)
    );

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_ph <= 1'b0;
        end else begin
            r_st <= n_st;
            r_ph <= n_ph;
        end
    end

    // Next state: each multiply step has a product phase and a write phase.
    always_comb begin
        n_st = r_st;
        n_ph = r_ph;
        case (r_st)
            ST_IDLE: begin
                n_ph = 1'b0;
                if (i_start) begin
                    n_st = ST_PRED_V;
                end
            end
            ST_DIV: begin
                if (!r_ph) begin
                    n_ph = 1'b1;
                end else if (!w_busy0 && !w_busy1) begin
                    n_ph = 1'b0;
                    n_st = ST_VEL;
                end
            end
            ST_DONE: begin
                if (i_ack) begin
                    n_st = ST_IDLE;
                end
            end
            default: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    case (r_st)
                        ST_PRED_V: n_st = r_fresh ? ST_T00 : ST_DONE;
                        ST_T00:    n_st = ST_T01;
                        ST_T01:    n_st = ST_PP00;
                        ST_PP00:   n_st = ST_DIV;
                        ST_VEL:    n_st = ST_DRIFT;
                        ST_DRIFT:  n_st = ST_P00;
                        ST_P00:    n_st = ST_P01;
                        ST_P01:    n_st = ST_P10;
                        ST_P10:    n_st = ST_P11;
                        default:   n_st = ST_DONE;
                    endcase
                end
            end
        endcase
    end

    // Filter state: velocity, drift and covariance.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel   <= '0;
            r_drift <= '0;
            r_p0    <= COV0;
            r_p1    <= '0;
            r_p2    <= '0;
            r_p3    <= COV0;
        end else if (r_ph) begin
            case (r_st)
                ST_PRED_V: begin
                    if (!r_fresh) begin
                        r_vel <= w_res;
                    end
                end
                ST_VEL:   r_vel   <= w_res;
                ST_DRIFT: r_drift <= w_res;
                ST_P00:   r_p0    <= w_res;
                ST_P01:   r_p1    <= w_res;
                ST_P10:   r_p2    <= w_res;
                ST_P11:   r_p3    <= w_res;
                default: begin
                    r_vel <= r_vel;
                end
            endcase
        end
    end

    // Working registers: product, predictions and gains.
    always_ff @(posedge i_clk) begin
        r_prod <= w_a * w_b;
        if ((r_st == ST_IDLE) && i_start) begin
            r_acc   <= i_acc;
            r_dt    <= i_dt;
            r_z     <= i_z;
            r_fresh <= i_fresh;
            r_zero  <= i_zero;
        end
        if (w_div_go) begin
            r_kz    <= (w_den <= 34'sd0);
            r_innov <= sat32(66'(r_z) - 66'(r_vp));
            r_pp11  <= sat32(66'(r_p3) + $signed(66'(i_qd)));
        end
        if ((r_st == ST_DIV) && r_ph && !w_busy0 && !w_busy1) begin
            r_k0 <= r_kz ? 32'sd0 : w_q0;
            r_k1 <= r_kz ? 32'sd0 : w_q1;
        end
        if (r_ph) begin
            case (r_st)
                ST_PRED_V: r_vp <= w_res;
                ST_T00:    r_t00 <= w_res;
                ST_T01: begin
                    r_pp01 <= w_res;
                    r_pp10 <= w_res2;
                end
                ST_PP00:   r_pp00 <= w_res;
                default: begin
                    r_vp <= r_vp;
                end
            endcase
        end
    end

    assign o_done = (r_st == ST_DONE);
    assign o_vel  = r_vel;

endmodule

`default_nettype wire

/* hdl/kvk_merge.sv */
// Output stage: joins the two lane estimates and the activity flag into one
// result transaction and holds it until taken. Depends on kvk_if.
`default_nettype none

module kvk_merge (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire logic signed [31:0] i_vel_x,
    input  wire logic signed [31:0] i_vel_y,
    input  wire logic               i_active,
    output logic                    o_free,
    kvk_out_if.source               o_out
);
    logic               r_valid;
    logic signed [31:0] r_vx, r_vy;
    logic               r_act;

    // Valid flag of the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_vx  <= i_vel_x;
            r_vy  <= i_vel_y;
            r_act <= i_active;
        end
    end

    assign o_free           = !r_valid || o_out.ready;
    assign o_out.valid      = r_valid;
    assign o_out.est_vel_x  = r_vx;
    assign o_out.est_vel_y  = r_vy;
    assign o_out.est_active = r_act;

endmodule

`default_nettype wire

/* hdl/two_axis_velocity_kalman_core.sv */
// An untrusted tick goes straight to the merge register; a tick without a measurement
// runs the velocity prediction step only, and one with a measurement runs ten multiply
// steps plus a gain divide (24 radix-4 iterations), then waits for the merge register.
// Only one tick is in flight: the next is accepted after the result is loaded; both axes run in parallel lanes.
// Reset (synchronous, active low): estimates and drift zero, covariance 4.0 on
// the diagonal, a restart pending, noise registers at their defaults.
`default_nettype none

module two_axis_velocity_kalman_core #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    kvk_in_if.sink                            i_in,
    kvk_out_if.source                         o_out,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [kvk_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import kvk_pkg::*;

    logic [CFG_W-1:0]   r_qv, r_qd, r_r;
    logic               r_busy, r_act, r_restart;
    logic               w_acc, w_start, w_fin, w_free;
    logic               w_done_x, w_done_y;
    logic signed [31:0] w_vel_x, w_vel_y;
    logic [1:0]         w_idx;
    logic               w_wr;

    // Configuration registers.
    assign w_idx  = paddr[3:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qv <= RST_Q_VEL;
            r_qd <= RST_Q_DRIFT;
            r_r  <= RST_R_MEAS;
        end else if (w_wr) begin
            case (w_idx)
                REG_Q_VEL:   r_qv <= pwdata[CFG_W-1:0];
                REG_Q_DRIFT: r_qd <= pwdata[CFG_W-1:0];
                REG_R_MEAS:  r_r  <= pwdata[CFG_W-1:0];
                default:     r_qv <= r_qv;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_Q_VEL:   prdata = {8'd0, r_qv};
            REG_Q_DRIFT: prdata = {8'd0, r_qd};
            REG_R_MEAS:  prdata = {8'd0, r_r};
            default:     prdata = '0;
        endcase
    end

    // Tick control: one transaction in flight, restart tracking.
    assign i_in.ready = !r_busy;
    assign w_acc      = i_in.valid && !r_busy;
    assign w_start    = w_acc && i_in.source_ready;
    assign w_fin      = r_busy && (!r_act || (w_done_x && w_done_y)) && w_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_act     <= 1'b0;
            r_restart <= 1'b1;
        end else if (w_acc) begin
            r_busy    <= 1'b1;
            r_act     <= i_in.source_ready;
            r_restart <= !i_in.source_ready;
        end else if (w_fin) begin
            r_busy <= 1'b0;
        end
    end

    // Axis lanes.
    kvk_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_fresh (i_in.new_measure),
        .i_zero  (r_restart),
        .i_acc   (i_in.accel_x),
        .i_dt    (i_in.time_step),
        .i_z     (i_in.meas_vel_x),
        .i_qv    (r_qv),
        .i_qd    (r_qd),
        .i_r     (r_r),
        .i_ack   (w_fin),
        .o_done  (w_done_x),
        .o_vel   (w_vel_x)
    );

    kvk_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_fresh (i_in.new_measure),
        .i_zero  (r_restart),
        .i_acc   (i_in.accel_y),
        .i_dt    (i_in.time_step),
        .i_z     (i_in.meas_vel_y),
        .i_qv    (r_qv),
        .i_qd    (r_qd),
        .i_r     (r_r),
        .i_ack   (w_fin),
        .o_done  (w_done_y),
        .o_vel   (w_vel_y)
    );

    // Merge both lanes into the result register.
    kvk_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_fin),
        .i_vel_x  (w_vel_x),
        .i_vel_y  (w_vel_y),
        .i_active (r_act),
        .o_free   (w_free),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire

/* hdl/kvk_checker.sv */
// Port-level checks of the velocity Kalman core, bound to the top level.
// Depends on two_axis_velocity_kalman_core_defines.svh.
`default_nettype none

`include "two_axis_velocity_kalman_core_defines.svh"

module kvk_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               i_in_ready,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire logic signed [31:0] i_out_vel_x,
    input wire logic signed [31:0] i_out_vel_y,
    input wire logic               i_out_active,
    input wire logic               i_pready
);
    // One tick at a time: after a transaction the input side closes.
    `KVK_ASSERT_NEXT(a_one_in_flight, i_in_valid && i_in_ready, !i_in_ready)

    // A stalled result holds.
    `KVK_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_vel_x) && $stable(i_out_vel_y) && $stable(i_out_active))

    // Whenever a new result appears, the input side is open in the same cycle.
    `KVK_ASSERT_ALWAYS(a_result_frees_input, !$rose(i_out_valid) || i_in_ready)

    // Reset empties the result register and opens the input, and the bus never waits.
    `KVK_ASSERT_RAW(a_reset_state, !i_rst_n |=> (!i_out_valid && i_in_ready && i_pready))

endmodule

bind two_axis_velocity_kalman_core kvk_checker u_kvk_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_vel_x  (o_out.est_vel_x),
    .i_out_vel_y  (o_out.est_vel_y),
    .i_out_active (o_out.est_active),
    .i_pready     (pready)
);

`default_nettype wire
